/* hw/rtl/tws_pkg.sv */
// tws_pkg: shared types and constants for the three-wire serial master.
// Beat structs, sequencer phase codes, opcodes and register indexes.
// No dependencies.
package tws_pkg;

    localparam int DATA_BITS   = 8;
    localparam int SHIFT_BITS  = 2 * DATA_BITS;
    localparam int TICK_W      = 8;
    localparam int BIT_CNT_W   = 4;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [TICK_W-1:0] HALF_PERIOD_RESET  = 8'd4;
    localparam logic [TICK_W-1:0] ENABLE_SETUP_RESET = 8'd4;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE_SETUP = 1'd1;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } opcode_t;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_SETUP  = 4'd1,
        PH_TXLOW  = 4'd2,
        PH_TXHIGH = 4'd3,
        PH_RXGAP  = 4'd4,
        PH_RXHIGH = 4'd5,
        PH_RXLOW  = 4'd6,
        PH_HOLD   = 4'd7
    } phase_t;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [7:0]           command_byte;
        logic [7:0]           write_byte;
        logic                 io_in;
    } in_beat_t;

    typedef struct packed {
        logic                 chip_enable;
        logic                 serial_clock;
        logic                 io_out;
        logic                 io_drive;
        logic                 busy_res;
        logic                 done_res;
        logic [DATA_BITS-1:0] read_byte;
    } out_beat_t;

    typedef struct packed {
        logic [TICK_W-1:0] half_period_ticks;
        logic [TICK_W-1:0] enable_setup_ticks;
    } cfg_t;

endpackage

/* hw/rtl/tws_cfg_regs.sv */
// tws_cfg_regs: configuration register file (half period, enable setup).
// Depends on tws_pkg.
module tws_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tws_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tws_pkg::CFG_DATA_W-1:0]    cfg_data,
    output tws_pkg::cfg_t                     cfg
);
    import tws_pkg::*;

    logic [TICK_W-1:0] half_period_reg;
    logic [TICK_W-1:0] enable_setup_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg  <= HALF_PERIOD_RESET;
            enable_setup_reg <= ENABLE_SETUP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HALF_PERIOD:  half_period_reg  <= cfg_data[TICK_W-1:0];
                CFG_ENABLE_SETUP: enable_setup_reg <= cfg_data[TICK_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg.half_period_ticks  = half_period_reg;
    assign cfg.enable_setup_ticks = enable_setup_reg;

endmodule

/* hw/rtl/tws_seq.sv */
// tws_seq: pin sequencer state and its one-tick update.
// Computes the result beat for the tick held in the input register.
// Depends on tws_pkg.
module tws_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  tws_pkg::in_beat_t  item,
    input  tws_pkg::cfg_t      cfg,
    output tws_pkg::out_beat_t result
);
    import tws_pkg::*;

    phase_t                  phase_reg,     phase_next;
    logic [BIT_CNT_W-1:0]    bit_count_reg, bit_count_next;
    logic [TICK_W-1:0]       tick_count_reg, tick_count_next;
    logic [SHIFT_BITS-1:0]   out_shift_reg, out_shift_next;
    logic [DATA_BITS-1:0]    in_shift_reg,  in_shift_next;
    logic                    is_read_reg,   is_read_next;
    logic                    done_next;

    logic                    active;
    logic [TICK_W-1:0]       raw_limit;
    logic [TICK_W-1:0]       limit;
    logic [TICK_W:0]         tick_inc;
    logic                    period_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= '0;
            tick_count_reg <= '0;
            out_shift_reg  <= '0;
            in_shift_reg   <= '0;
            is_read_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            tick_count_reg <= tick_count_next;
            out_shift_reg  <= out_shift_next;
            in_shift_reg   <= in_shift_next;
            is_read_reg    <= is_read_next;
        end
    end

    // unused phase codes behave as idle
    assign active = (phase_reg == PH_SETUP)  || (phase_reg == PH_TXLOW)  ||
                    (phase_reg == PH_TXHIGH) || (phase_reg == PH_RXGAP)  ||
                    (phase_reg == PH_RXHIGH) || (phase_reg == PH_RXLOW)  ||
                    (phase_reg == PH_HOLD);

    assign raw_limit  = ((phase_reg == PH_SETUP) || (phase_reg == PH_HOLD)) ?
                        cfg.enable_setup_ticks : cfg.half_period_ticks;
    // a zero count acts as one tick
    assign limit      = (raw_limit == '0) ? TICK_W'(1) : raw_limit;
    assign tick_inc   = {1'b0, tick_count_reg} + (TICK_W+1)'(1);
    assign period_end = (tick_inc >= {1'b0, limit});

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        tick_count_next = tick_count_reg;
        out_shift_next  = out_shift_reg;
        in_shift_next   = in_shift_reg;
        is_read_next    = is_read_reg;
        done_next       = 1'b0;

        if (!active)
        begin
            phase_next = PH_IDLE;
            if ((item.opcode == OP_WRITE) || (item.opcode == OP_READ))
            begin
                is_read_next    = (item.opcode == OP_READ);
                out_shift_next  = (item.opcode == OP_READ) ?
                                  {{DATA_BITS{1'b0}}, item.command_byte} :
                                  {item.write_byte, item.command_byte};
                bit_count_next  = '0;
                tick_count_next = '0;
                phase_next      = PH_SETUP;
            end
        end
        else if (!period_end)
        begin
            tick_count_next = tick_inc[TICK_W-1:0];
        end
        else
        begin
            tick_count_next = '0;
            case (phase_reg)
                PH_SETUP:  phase_next = PH_TXLOW;
                PH_TXLOW:  phase_next = PH_TXHIGH;
                PH_TXHIGH:
                begin
                    out_shift_next = out_shift_reg >> 1;
                    if (is_read_reg && (bit_count_reg == BIT_CNT_W'(DATA_BITS - 1)))
                    begin
                        bit_count_next = '0;
                        phase_next     = PH_RXGAP;
                    end
                    else if (bit_count_reg >= BIT_CNT_W'(SHIFT_BITS - 1))
                    begin
                        bit_count_next = '0;
                        phase_next     = PH_HOLD;
                    end
                    else
                    begin
                        bit_count_next = bit_count_reg + BIT_CNT_W'(1);
                        phase_next     = PH_TXLOW;
                    end
                end
                PH_RXGAP:  phase_next = PH_RXHIGH;
                PH_RXHIGH: phase_next = PH_RXLOW;
                PH_RXLOW:
                begin
                    in_shift_next = {item.io_in, in_shift_reg[DATA_BITS-1:1]};
                    if (bit_count_reg >= BIT_CNT_W'(DATA_BITS - 1))
                    begin
                        bit_count_next = '0;
                        phase_next     = PH_HOLD;
                    end
                    else
                    begin
                        bit_count_next = bit_count_reg + BIT_CNT_W'(1);
                        phase_next     = PH_RXHIGH;
                    end
                end
                default:
                begin
                    // end of hold: enable drops
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
            endcase
        end
    end

    // pin levels after this tick
    always_comb
    begin
        logic busy;
        logic drive;
        busy  = (phase_next != PH_IDLE);
        drive = (phase_next == PH_TXLOW) || (phase_next == PH_TXHIGH);
        result.chip_enable  = busy;
        result.serial_clock = (phase_next == PH_TXHIGH) || (phase_next == PH_RXHIGH);
        result.io_out       = drive & out_shift_next[0];
        result.io_drive     = drive;
        result.busy_res     = busy;
        result.done_res     = done_next;
        result.read_byte    = in_shift_next;
    end

endmodule

/* hw/rtl/three_wire_serial_master_unit.sv */
// three_wire_serial_master_unit: top level of the three-wire (CE/SCLK/IO) master.
// Input register, sequencer step and result register; config register file.
// Depends on tws_pkg, tws_cfg_regs, tws_seq.
//
//   channel  | handshake              | beat / data
//   ---------+------------------------+---------------------------------------
//   input    | in_valid / in_stall    | in_data  (opcode, bytes, io_in)
//   result   | out_valid / out_stall  | out_data (pin levels, busy, done, rx)
//   config   | cfg_we                 | cfg_index, cfg_data (no read-back)
//
// One input beat is one sequencer tick. A beat is held in the input register,
// then in the result register; the sequencer state and the result register
// update together when it moves on, and the rate is one beat per cycle while
// the result side does not stall. The result register frees the input side
// while a result waits: the input stalls only when both registers are full and
// out_stall is high. Reset clears the handshake flags, the sequencer (idle) and
// the tick config (both counts 4); payload registers are not reset.
module three_wire_serial_master_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  tws_pkg::in_beat_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output tws_pkg::out_beat_t                out_data,
    input  logic                              cfg_we,
    input  logic [tws_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tws_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tws_pkg::*;

    logic      in_valid_reg;
    in_beat_t  in_data_reg;
    logic      out_valid_reg;
    out_beat_t out_data_reg;

    logic      step;        // beat moves from input reg to result reg
    logic      in_take;     // input handshake completes
    cfg_t      cfg;
    out_beat_t seq_result;

    assign step     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !step;
    assign in_take  = in_valid && !in_stall;

    tws_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tws_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_data_reg),
        .cfg    (cfg),
        .result (seq_result)
    );

    // handshake flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (step)
                in_valid_reg <= 1'b0;

            if (step)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_data_reg <= in_data;
        if (step)
            out_data_reg <= seq_result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
